// ----- rtl/bole_pkg.sv -----
// bole_pkg: shared types and constants of the bounded ordered list engine
// no dependencies; compiled before every other file of the block
`default_nettype none
package bole_pkg;

	localparam int KIND_W          = 3;
	localparam int VALUE_IN_W      = 32;
	localparam int POS_W           = 5;
	localparam int STATUS_W        = 2;
	localparam int READ_W          = 32;
	localparam int LEN_W           = 5;
	localparam int DEF_DEPTH       = 16;
	localparam int DEF_VALUE_WIDTH = 32;

	typedef enum logic [KIND_W-1:0] {
		KIND_APPEND  = 3'd0,
		KIND_INSERT  = 3'd1,
		KIND_ERASE   = 3'd2,
		KIND_READ    = 3'd3,
		KIND_SINSERT = 3'd4,
		KIND_SWAP    = 3'd5,
		KIND_CLEAR   = 3'd6,
		KIND_SORT    = 3'd7
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK      = 2'd0,
		STATUS_BAD_POS = 2'd1,
		STATUS_FULL    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SORT,
		S_INSERT,
		S_SWAP
	} state_t;

	typedef enum logic [2:0] {
		SEL_KEEP,
		SEL_LEFT,
		SEL_RIGHT,
		SEL_NEW,
		SEL_ALT
	} cell_sel_t;

	typedef struct packed {
		logic gt;
		logic lt_right;
	} cell_flags_t;

endpackage
`default_nettype wire

// ----- rtl/bole_if.sv -----
// bole_in_if / bole_out_if: valid/ready channels of the list engine
// depends on bole_pkg for the payload widths
`default_nettype none
interface bole_in_if;
	logic                             valid;
	logic                             ready;
	logic [bole_pkg::KIND_W-1:0]      kind;
	logic [bole_pkg::VALUE_IN_W-1:0]  value;
	logic [bole_pkg::POS_W-1:0]       position;
	logic [bole_pkg::POS_W-1:0]       second_position;

	modport source (output valid, kind, value, position, second_position, input ready);
	modport sink (input valid, kind, value, position, second_position, output ready);
endinterface

interface bole_out_if;
	logic                             valid;
	logic                             ready;
	logic [bole_pkg::STATUS_W-1:0]    status;
	logic [bole_pkg::READ_W-1:0]      read_value;
	logic [bole_pkg::LEN_W-1:0]       length;
	logic                             empty_res;

	modport source (output valid, status, read_value, length, empty_res, input ready);
	modport sink (input valid, status, read_value, length, empty_res, output ready);
endinterface
`default_nettype wire

// ----- rtl/bole_cell.sv -----
// bole_cell: one list slot; holds an entry, loads from a neighbor or a bus
// and reports its compares against the broadcast value and its right neighbor
// depends on bole_pkg
`default_nettype none
module bole_cell #(
	parameter int VALUE_WIDTH = bole_pkg::DEF_VALUE_WIDTH
) (
	input  logic                     clk,
	input  bole_pkg::cell_sel_t      sel,
	input  logic [VALUE_WIDTH-1:0]   left_val,
	input  logic [VALUE_WIDTH-1:0]   right_val,
	input  logic [VALUE_WIDTH-1:0]   new_val,
	input  logic [VALUE_WIDTH-1:0]   alt_val,
	input  logic [VALUE_WIDTH-1:0]   cmp_val,
	output logic [VALUE_WIDTH-1:0]   entry,
	output bole_pkg::cell_flags_t    flags
);

	logic [VALUE_WIDTH-1:0] entry_q;

	always_ff @(posedge clk) begin
		case (sel)
			bole_pkg::SEL_LEFT:  entry_q <= left_val;
			bole_pkg::SEL_RIGHT: entry_q <= right_val;
			bole_pkg::SEL_NEW:   entry_q <= new_val;
			bole_pkg::SEL_ALT:   entry_q <= alt_val;
			default:             entry_q <= entry_q;
		endcase
	end

	assign entry          = entry_q;
	assign flags.gt       = entry_q > cmp_val;
	assign flags.lt_right = entry_q < right_val;

endmodule
`default_nettype wire

// ----- rtl/bounded_ordered_list_engine_unit.sv -----
// bounded_ordered_list_engine_unit: top level, sequencer and row of list cells
// depends on bole_pkg, bole_if (bole_in_if, bole_out_if) and bole_cell
//
// usage: one command transaction on in_ch yields exactly one result transaction
// on out_ch. commands: append, insert at, erase, retrieve, sorted insert,
// swap, clear and sort descending, on a list of up to DEPTH entries.
// append, insert at, erase, retrieve, clear, and failed commands finish in
// the cycle they are accepted; the result is registered and shows in the next
// cycle, and the next command can be taken in that same cycle.
// swap reads both slots when accepted, then writes them back in S_SWAP.
// sort runs DEPTH odd-even compare-exchange passes in S_SORT, or finishes
// in the cycle it is accepted when the list is already marked sorted.
// sorted insert on a sorted list finishes when accepted, else S_SORT, then S_INSERT.
// in_ch.ready is low while a multi-cycle command runs and while a result
// waits in the output register and out_ch.ready is low; a stalled receiver
// thus holds off new commands but never loses a result.
// reset empties the list and clears the sorted mark; entry storage is not
// cleared, slots past the length are never visible
`default_nettype none
module bounded_ordered_list_engine_unit #(
	parameter int DEPTH       = bole_pkg::DEF_DEPTH,
	parameter int VALUE_WIDTH = bole_pkg::DEF_VALUE_WIDTH
) (
	input  logic         clk,
	input  logic         arst_n,
	bole_in_if.sink      in_ch,
	bole_out_if.source   out_ch
);

	localparam int IW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = ((CW > bole_pkg::POS_W) ? CW : bole_pkg::POS_W) + 1;

	bole_pkg::state_t       state_q, state_d;
	logic [CW-1:0]          cnt_q, cnt_d;
	logic                   sorted_q, sorted_d;
	logic                   sins_q, sins_d;
	logic [IW-1:0]          scnt_q, scnt_d;
	logic [IW-1:0]          sw1_q, sw2_q;
	logic [VALUE_WIDTH-1:0] val_q, swa_q, swb_q;
	logic                   cap_val, cap_swap;

	logic                   in_ready, acc;
	bole_pkg::kind_t        kind;
	logic [63:0]            v_wide;
	logic [VALUE_WIDTH-1:0] v_in;
	logic [CMPW-1:0]        p1e, p2e, cnte;
	logic                   ins_ok, ok1, ok2, full;
	logic [IW-1:0]          idx1, idx2;
	logic [VALUE_WIDTH-1:0] rd1, rd2;

	logic [VALUE_WIDTH-1:0] ent [DEPTH];
	bole_pkg::cell_flags_t  flg [DEPTH];
	bole_pkg::cell_sel_t    sel [DEPTH];
	logic [VALUE_WIDTH-1:0] new_bus, alt_bus, cmp_bus;
	logic [DEPTH-1:0]       gtm, gt_prev, xl, xl_prev;
	logic                   front;

	logic                   do_ins, do_del, do_sins, do_sort, do_swapw;
	logic [IW-1:0]          k_idx;

	logic                   load_out;
	bole_pkg::status_t      st_d;
	logic [VALUE_WIDTH-1:0] rd_d;
	logic [63:0]            rd_wide;
	logic                   out_valid_q;
	bole_pkg::status_t      status_q;
	logic [bole_pkg::READ_W-1:0] read_q;
	logic [bole_pkg::LEN_W-1:0]  len_q;
	logic                   empty_q;

	// input decode
	assign kind     = bole_pkg::kind_t'(in_ch.kind);
	assign v_wide   = 64'(in_ch.value);
	assign v_in     = v_wide[VALUE_WIDTH-1:0];
	assign p1e      = CMPW'(in_ch.position);
	assign p2e      = CMPW'(in_ch.second_position);
	assign cnte     = CMPW'(cnt_q);
	assign full     = cnt_q == CW'(DEPTH);
	assign ins_ok   = (p1e != '0) && (p1e <= cnte + CMPW'(1));
	assign ok1      = (p1e != '0) && (p1e <= cnte);
	assign ok2      = (p2e != '0) && (p2e <= cnte);
	assign idx1     = IW'(p1e - CMPW'(1));
	assign idx2     = IW'(p2e - CMPW'(1));

	assign in_ready    = (state_q == bole_pkg::S_IDLE) && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = in_ready;
	assign acc         = in_ch.valid && in_ready;

	// slot reads for retrieve and swap
	always_comb begin
		rd1 = '0;
		rd2 = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (IW'(i) == idx1) rd1 = rd1 | ent[i];
			if (IW'(i) == idx2) rd2 = rd2 | ent[i];
		end
	end

	// sequencer
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		sorted_d = sorted_q;
		sins_d   = sins_q;
		scnt_d   = scnt_q;
		cap_val  = 1'b0;
		cap_swap = 1'b0;
		do_ins   = 1'b0;
		do_del   = 1'b0;
		do_sins  = 1'b0;
		do_sort  = 1'b0;
		do_swapw = 1'b0;
		k_idx    = idx1;
		load_out = 1'b0;
		st_d     = bole_pkg::STATUS_OK;
		rd_d     = '0;
		case (state_q)
			bole_pkg::S_IDLE: begin
				if (acc) begin
					case (kind)
						bole_pkg::KIND_APPEND, bole_pkg::KIND_INSERT: begin
							load_out = 1'b1;
							if (kind == bole_pkg::KIND_APPEND) k_idx = IW'(cnt_q);
							if (kind == bole_pkg::KIND_INSERT && !ins_ok) begin
								st_d = bole_pkg::STATUS_BAD_POS;
							end else if (full) begin
								st_d = bole_pkg::STATUS_FULL;
							end else begin
								do_ins   = 1'b1;
								cnt_d    = cnt_q + CW'(1);
								sorted_d = 1'b0;
							end
						end
						bole_pkg::KIND_ERASE: begin
							load_out = 1'b1;
							if (!ok1) begin
								st_d = bole_pkg::STATUS_BAD_POS;
							end else begin
								do_del = 1'b1;
								cnt_d  = cnt_q - CW'(1);
							end
						end
						bole_pkg::KIND_READ: begin
							load_out = 1'b1;
							if (!ok1) st_d = bole_pkg::STATUS_BAD_POS;
							else rd_d = rd1;
						end
						bole_pkg::KIND_SINSERT: begin
							if (full) begin
								load_out = 1'b1;
								st_d     = bole_pkg::STATUS_FULL;
							end else if (sorted_q) begin
								load_out = 1'b1;
								do_sins  = 1'b1;
								cnt_d    = cnt_q + CW'(1);
							end else begin
								cap_val = 1'b1;
								sins_d  = 1'b1;
								scnt_d  = '0;
								state_d = bole_pkg::S_SORT;
							end
						end
						bole_pkg::KIND_SWAP: begin
							if (!(ok1 && ok2)) begin
								load_out = 1'b1;
								st_d     = bole_pkg::STATUS_BAD_POS;
							end else begin
								cap_swap = 1'b1;
								state_d  = bole_pkg::S_SWAP;
							end
						end
						bole_pkg::KIND_CLEAR: begin
							load_out = 1'b1;
							cnt_d    = '0;
						end
						bole_pkg::KIND_SORT: begin
							if (sorted_q) begin
								load_out = 1'b1;
							end else begin
								sins_d  = 1'b0;
								scnt_d  = '0;
								state_d = bole_pkg::S_SORT;
							end
						end
						default: ;
					endcase
				end
			end
			bole_pkg::S_SORT: begin
				do_sort = 1'b1;
				scnt_d  = scnt_q + IW'(1);
				if (scnt_q == IW'(DEPTH - 1)) begin
					sorted_d = 1'b1;
					if (sins_q) begin
						state_d = bole_pkg::S_INSERT;
					end else begin
						load_out = 1'b1;
						state_d  = bole_pkg::S_IDLE;
					end
				end
			end
			bole_pkg::S_INSERT: begin
				do_sins  = 1'b1;
				cnt_d    = cnt_q + CW'(1);
				load_out = 1'b1;
				state_d  = bole_pkg::S_IDLE;
			end
			bole_pkg::S_SWAP: begin
				do_swapw = 1'b1;
				sorted_d = 1'b0;
				load_out = 1'b1;
				state_d  = bole_pkg::S_IDLE;
			end
			default: state_d = bole_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bole_pkg::S_IDLE;
			cnt_q       <= '0;
			sorted_q    <= 1'b0;
			sins_q      <= 1'b0;
			scnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			sorted_q <= sorted_d;
			sins_q   <= sins_d;
			scnt_q   <= scnt_d;
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	assign rd_wide = 64'(rd_d);

	always_ff @(posedge clk) begin
		if (cap_val) val_q <= v_in;
		if (cap_swap) begin
			sw1_q <= idx1;
			sw2_q <= idx2;
			swa_q <= rd1;
			swb_q <= rd2;
		end
		if (load_out) begin
			status_q <= st_d;
			read_q   <= rd_wide[bole_pkg::READ_W-1:0];
			len_q    <= bole_pkg::LEN_W'(cnt_d);
			empty_q  <= cnt_d == '0;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.status     = status_q;
	assign out_ch.read_value = read_q;
	assign out_ch.length     = len_q;
	assign out_ch.empty_res  = empty_q;

	// broadcast buses
	assign new_bus = (state_q == bole_pkg::S_SWAP) ? swb_q :
		(state_q == bole_pkg::S_IDLE) ? v_in : val_q;
	assign alt_bus = swa_q;
	assign cmp_bus = (state_q == bole_pkg::S_IDLE) ? v_in : val_q;

	// neighbor-local flags
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			gtm[i] = flg[i].gt && (CW'(i) < cnt_q);
			xl[i]  = (1'(i % 2) == scnt_q[0]) && (CW'(i + 1) < cnt_q) && flg[i].lt_right;
		end
	end
	assign gt_prev = {gtm[DEPTH-2:0], 1'b0};
	assign xl_prev = {xl[DEPTH-2:0], 1'b0};
	// new value goes first when the list is empty or it is larger than the head
	assign front   = (cnt_q == '0) || (cmp_bus > ent[0]);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VALUE_WIDTH-1:0] left_v, right_v;

		assign left_v  = (i == 0) ? '0 : ent[(i == 0) ? 0 : i - 1];
		assign right_v = (i == DEPTH - 1) ? '0 : ent[(i == DEPTH - 1) ? i : i + 1];

		always_comb begin
			sel[i] = bole_pkg::SEL_KEEP;
			if (do_ins) begin
				if (IW'(i) == k_idx) sel[i] = bole_pkg::SEL_NEW;
				else if (IW'(i) > k_idx) sel[i] = bole_pkg::SEL_LEFT;
			end else if (do_del) begin
				if (IW'(i) >= k_idx) sel[i] = bole_pkg::SEL_RIGHT;
			end else if (do_sins) begin
				if (front) begin
					sel[i] = (i == 0) ? bole_pkg::SEL_NEW : bole_pkg::SEL_LEFT;
				end else if (i != 0) begin
					if (!gtm[i] && ((i == 1) || gt_prev[i])) sel[i] = bole_pkg::SEL_NEW;
					else if ((i >= 2) && !gt_prev[i]) sel[i] = bole_pkg::SEL_LEFT;
				end
			end else if (do_sort) begin
				if (xl[i]) sel[i] = bole_pkg::SEL_RIGHT;
				else if (xl_prev[i]) sel[i] = bole_pkg::SEL_LEFT;
			end else if (do_swapw) begin
				if (IW'(i) == sw1_q) sel[i] = bole_pkg::SEL_NEW;
				else if (IW'(i) == sw2_q) sel[i] = bole_pkg::SEL_ALT;
			end
		end

		bole_cell #(
			.VALUE_WIDTH(VALUE_WIDTH)
		) u_cell (
			.clk       (clk),
			.sel       (sel[i]),
			.left_val  (left_v),
			.right_val (right_v),
			.new_val   (new_bus),
			.alt_val   (alt_bus),
			.cmp_val   (cmp_bus),
			.entry     (ent[i]),
			.flags     (flg[i])
		);
	end

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count beyond depth");

	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != bole_pkg::S_IDLE) |-> !in_ch.ready)
		else $error("command taken while busy");

	a_busy_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != bole_pkg::S_IDLE) |-> !out_valid_q)
		else $error("result pending during multi-cycle command");

	a_sort_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bole_pkg::S_SORT && state_d != bole_pkg::S_SORT) |=> sorted_q)
		else $error("sorted mark not set after sort");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && kind == bole_pkg::KIND_CLEAR) |=> (cnt_q == '0 && out_valid_q))
		else $error("clear did not empty the list");

endmodule
`default_nettype wire
